>>> hdl/oha_pkg.sv
// Shared types and constants for the owned handle allocator.
// Used by oha_front, oha_back and owned_handle_allocator_top; depends on nothing.
`default_nettype none

package oha_pkg;

  localparam int TABLE_SIZE   = 64;
  localparam int FIRST_HANDLE = 3;
  localparam int HW           = $clog2(TABLE_SIZE);
  localparam int CNT_W        = $clog2(TABLE_SIZE + 1);
  localparam int HANDLE_W     = 6;
  localparam int OBJ_W        = 32;
  localparam int OWNER_W      = 16;
  localparam int CMD_W        = 3;

  localparam logic [CNT_W-1:0] TABLE_SIZE_C   = CNT_W'(TABLE_SIZE);
  localparam logic [CNT_W-1:0] FIRST_HANDLE_C = CNT_W'(FIRST_HANDLE);

  localparam logic [CMD_W-1:0] CMD_ACQUIRE  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_RELEASE  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_VALIDATE = 3'd2;
  localparam logic [CMD_W-1:0] CMD_GET      = 3'd3;
  localparam logic [CMD_W-1:0] CMD_SWEEP    = 3'd4;

  typedef enum logic [2:0] {
    OP_ACQ,
    OP_REL,
    OP_CHECK,
    OP_SWEEP,
    OP_BAD
  } oha_op_e;

  typedef enum logic [1:0] {
    STAT_OK,
    STAT_RANGE,
    STAT_FOREIGN,
    STAT_FULL
  } oha_status_e;

  typedef struct packed {
    oha_op_e             op;
    logic [HANDLE_W-1:0] handle;
    logic [OWNER_W-1:0]  owner;
    logic [OBJ_W-1:0]    obj;
    logic                is_dir;
  } oha_cmd_t;

  typedef struct packed {
    logic     valid;
    oha_cmd_t cmd;
  } oha_req_t;

  typedef struct packed {
    logic [OBJ_W-1:0]   obj;
    logic [OWNER_W-1:0] owner;
    logic               is_dir;
  } oha_entry_t;

  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    logic [OBJ_W-1:0]    obj;
    logic                is_dir;
    oha_status_e         status;
    logic                released;
    logic                last;
  } oha_res_t;

endpackage

`default_nettype wire

>>> hdl/oha_front.sv
// Front end: accepts command items, decodes them and holds them in a two-entry queue.
// Depends on oha_pkg.
`default_nettype none

module oha_front (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            push,
  output logic                           full,
  input  wire  [oha_pkg::CMD_W-1:0]      command_i,
  input  wire  [oha_pkg::HANDLE_W-1:0]   handle_i,
  input  wire  [oha_pkg::OWNER_W-1:0]    owner_id_i,
  input  wire  [oha_pkg::OBJ_W-1:0]      object_ref_i,
  input  wire                            object_is_dir_i,
  input  wire                            deq_i,
  output oha_pkg::oha_req_t              req_o
);

  oha_pkg::oha_cmd_t qmem [2];
  oha_pkg::oha_cmd_t dec;
  logic              wr_q, wr_d, rd_q, rd_d;
  logic [1:0]        cnt_q, cnt_d;
  logic              enq;

  always_comb begin
    dec.handle = handle_i;
    dec.owner  = owner_id_i;
    dec.obj    = object_ref_i;
    dec.is_dir = object_is_dir_i;
    case (command_i)
      oha_pkg::CMD_ACQUIRE:  dec.op = oha_pkg::OP_ACQ;
      oha_pkg::CMD_RELEASE:  dec.op = oha_pkg::OP_REL;
      oha_pkg::CMD_VALIDATE: dec.op = oha_pkg::OP_CHECK;
      oha_pkg::CMD_GET:      dec.op = oha_pkg::OP_CHECK;
      oha_pkg::CMD_SWEEP:    dec.op = oha_pkg::OP_SWEEP;
      default:               dec.op = oha_pkg::OP_BAD;
    endcase
  end

  assign full = (cnt_q == 2'd2);
  assign enq  = push && !full;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (enq) begin
      wr_d = ~wr_q;
    end
    if (deq_i) begin
      rd_d = ~rd_q;
    end
    case ({enq, deq_i})
      2'b10:   cnt_d = cnt_q + 2'd1;
      2'b01:   cnt_d = cnt_q - 2'd1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (enq) begin
      qmem[wr_q] <= dec;
    end
  end

  assign req_o.valid = (cnt_q != 2'd0);
  assign req_o.cmd   = qmem[rd_q];

endmodule

`default_nettype wire

>>> hdl/oha_back.sv
// Back end: handle table engine with entry and free-stack memories, plus the result queue.
// Depends on oha_pkg; takes decoded items from oha_front.
`default_nettype none

module oha_back (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  oha_pkg::oha_req_t   req_i,
  output logic                deq_o,
  input  wire                 pop,
  output logic                empty,
  output oha_pkg::oha_res_t   head_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EXEC   = 3'd1;
  localparam logic [2:0] S_SW_RD  = 3'd2;
  localparam logic [2:0] S_SW_EV  = 3'd3;
  localparam logic [2:0] S_SW_END = 3'd4;

  logic [2:0]                     state_q, state_d;
  oha_pkg::oha_cmd_t              cmd_q, cmd_d;
  logic [oha_pkg::HANDLE_W-1:0]   h_q, h_d;
  logic                           range_bad_q, range_bad_d;
  logic                           from_stack_q, from_stack_d;
  logic                           full_q, full_d;
  logic [oha_pkg::CNT_W-1:0]      hw_q, hw_d;
  logic [oha_pkg::CNT_W-1:0]      free_cnt_q, free_cnt_d;
  logic [oha_pkg::CNT_W-1:0]      idx_q, idx_d;
  logic [oha_pkg::CNT_W-1:0]      cnt_m1;
  logic [oha_pkg::TABLE_SIZE-1:0] active_q, active_d;

  oha_pkg::oha_entry_t            entry_mem [oha_pkg::TABLE_SIZE];
  oha_pkg::oha_entry_t            entry_rd_q, entry_wdata;
  logic                           entry_re, entry_we;
  logic [oha_pkg::HW-1:0]         entry_raddr, entry_waddr;

  logic [oha_pkg::HW-1:0]         stack_mem [oha_pkg::TABLE_SIZE];
  logic [oha_pkg::HW-1:0]         stack_rd_q, stack_wdata, stack_raddr, stack_waddr;
  logic                           stack_re, stack_we;

  logic                           push_free;
  logic [oha_pkg::HW-1:0]         push_idx;
  logic [oha_pkg::HW-1:0]         acq_idx;
  logic [oha_pkg::HW-1:0]         cur_idx;

  logic                           emit;
  oha_pkg::oha_res_t              emit_res;

  oha_pkg::oha_res_t              oq_mem [2];
  logic                           oq_wr_q, oq_rd_q;
  logic [1:0]                     oq_cnt_q, oq_cnt_d;
  logic                           space, oq_pop;

  assign space  = (oq_cnt_q != 2'd2);
  assign cnt_m1 = free_cnt_q - oha_pkg::CNT_W'(1);
  assign acq_idx = from_stack_q ? stack_rd_q : h_q[oha_pkg::HW-1:0];
  assign cur_idx = idx_q[oha_pkg::HW-1:0];

  always_comb begin
    state_d      = state_q;
    cmd_d        = cmd_q;
    h_d          = h_q;
    range_bad_d  = range_bad_q;
    from_stack_d = from_stack_q;
    full_d       = full_q;
    hw_d         = hw_q;
    free_cnt_d   = free_cnt_q;
    idx_d        = idx_q;
    active_d     = active_q;
    deq_o        = 1'b0;
    entry_re     = 1'b0;
    entry_raddr  = '0;
    entry_we     = 1'b0;
    entry_waddr  = acq_idx;
    entry_wdata.obj    = cmd_q.obj;
    entry_wdata.owner  = cmd_q.owner;
    entry_wdata.is_dir = cmd_q.is_dir;
    stack_re     = 1'b0;
    stack_raddr  = cnt_m1[oha_pkg::HW-1:0];
    stack_we     = 1'b0;
    stack_waddr  = free_cnt_q[oha_pkg::HW-1:0];
    stack_wdata  = '0;
    push_free    = 1'b0;
    push_idx     = '0;
    emit         = 1'b0;
    emit_res     = '0;

    case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          deq_o        = 1'b1;
          cmd_d        = req_i.cmd;
          h_d          = req_i.cmd.handle;
          range_bad_d  = (32'(req_i.cmd.handle) < 32'(oha_pkg::FIRST_HANDLE)) ||
                         (32'(req_i.cmd.handle) >= 32'(hw_q));
          entry_re     = 1'b1;
          entry_raddr  = req_i.cmd.handle[oha_pkg::HW-1:0];
          from_stack_d = 1'b0;
          full_d       = 1'b0;
          state_d      = S_EXEC;
          case (req_i.cmd.op)
            oha_pkg::OP_ACQ: begin
              if (free_cnt_q != '0) begin
                // pop the most recently freed handle
                stack_re     = 1'b1;
                free_cnt_d   = cnt_m1;
                from_stack_d = 1'b1;
              end else if (hw_q < oha_pkg::TABLE_SIZE_C) begin
                h_d  = oha_pkg::HANDLE_W'(hw_q);
                hw_d = hw_q + oha_pkg::CNT_W'(1);
              end else begin
                full_d = 1'b1;
              end
            end
            oha_pkg::OP_SWEEP: begin
              idx_d   = oha_pkg::FIRST_HANDLE_C;
              state_d = S_SW_RD;
            end
            default: ;
          endcase
        end
      end

      S_EXEC: begin
        if (space) begin
          emit          = 1'b1;
          emit_res.last = 1'b1;
          state_d       = S_IDLE;
          case (cmd_q.op)
            oha_pkg::OP_ACQ: begin
              if (full_q) begin
                emit_res.status = oha_pkg::STAT_FULL;
              end else begin
                entry_we          = 1'b1;
                active_d[acq_idx] = 1'b1;
                emit_res.handle   = oha_pkg::HANDLE_W'(acq_idx);
                emit_res.obj      = cmd_q.obj;
                emit_res.is_dir   = cmd_q.is_dir;
                emit_res.status   = oha_pkg::STAT_OK;
              end
            end
            oha_pkg::OP_REL, oha_pkg::OP_CHECK: begin
              emit_res.handle = h_q;
              if (range_bad_q) begin
                emit_res.status = oha_pkg::STAT_RANGE;
              end else if (!active_q[h_q[oha_pkg::HW-1:0]] ||
                           (entry_rd_q.owner != cmd_q.owner)) begin
                emit_res.status = oha_pkg::STAT_FOREIGN;
              end else begin
                emit_res.obj    = entry_rd_q.obj;
                emit_res.is_dir = entry_rd_q.is_dir;
                emit_res.status = oha_pkg::STAT_OK;
                if (cmd_q.op == oha_pkg::OP_REL) begin
                  emit_res.released = 1'b1;
                  push_free         = 1'b1;
                  push_idx          = h_q[oha_pkg::HW-1:0];
                end
              end
            end
            default: ;
          endcase
        end
      end

      S_SW_RD: begin
        if (idx_q >= hw_q) begin
          state_d = S_SW_END;
        end else if (active_q[cur_idx]) begin
          entry_re    = 1'b1;
          entry_raddr = cur_idx;
          state_d     = S_SW_EV;
        end else begin
          idx_d = idx_q + oha_pkg::CNT_W'(1);
        end
      end

      S_SW_EV: begin
        if (entry_rd_q.owner != cmd_q.owner) begin
          idx_d   = idx_q + oha_pkg::CNT_W'(1);
          state_d = S_SW_RD;
        end else if (space) begin
          emit              = 1'b1;
          emit_res.handle   = oha_pkg::HANDLE_W'(cur_idx);
          emit_res.obj      = entry_rd_q.obj;
          emit_res.is_dir   = entry_rd_q.is_dir;
          emit_res.status   = oha_pkg::STAT_OK;
          emit_res.released = 1'b1;
          push_free         = 1'b1;
          push_idx          = cur_idx;
          idx_d             = idx_q + oha_pkg::CNT_W'(1);
          state_d           = S_SW_RD;
        end
      end

      S_SW_END: begin
        if (space) begin
          emit          = 1'b1;
          emit_res.last = 1'b1;
          state_d       = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase

    // drop the entry and put its handle on the free stack
    if (push_free) begin
      active_d[push_idx] = 1'b0;
      if (free_cnt_q < oha_pkg::TABLE_SIZE_C) begin
        stack_we    = 1'b1;
        stack_wdata = push_idx;
        free_cnt_d  = free_cnt_q + oha_pkg::CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      hw_q       <= oha_pkg::FIRST_HANDLE_C;
      free_cnt_q <= '0;
      active_q   <= '0;
    end else begin
      state_q    <= state_d;
      hw_q       <= hw_d;
      free_cnt_q <= free_cnt_d;
      active_q   <= active_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    h_q          <= h_d;
    range_bad_q  <= range_bad_d;
    from_stack_q <= from_stack_d;
    full_q       <= full_d;
    idx_q        <= idx_d;
  end

  // entry table
  always_ff @(posedge clk_i) begin
    if (entry_we) begin
      entry_mem[entry_waddr] <= entry_wdata;
    end
    if (entry_re) begin
      entry_rd_q <= entry_mem[entry_raddr];
    end
  end

  // free stack
  always_ff @(posedge clk_i) begin
    if (stack_we) begin
      stack_mem[stack_waddr] <= stack_wdata;
    end
    if (stack_re) begin
      stack_rd_q <= stack_mem[stack_raddr];
    end
  end

  // result queue
  assign empty  = (oq_cnt_q == 2'd0);
  assign oq_pop = pop && !empty;
  assign head_o = oq_mem[oq_rd_q];

  always_comb begin
    case ({emit, oq_pop})
      2'b10:   oq_cnt_d = oq_cnt_q + 2'd1;
      2'b01:   oq_cnt_d = oq_cnt_q - 2'd1;
      default: oq_cnt_d = oq_cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oq_wr_q  <= 1'b0;
      oq_rd_q  <= 1'b0;
      oq_cnt_q <= 2'd0;
    end else begin
      if (emit) begin
        oq_wr_q <= ~oq_wr_q;
      end
      if (oq_pop) begin
        oq_rd_q <= ~oq_rd_q;
      end
      oq_cnt_q <= oq_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      oq_mem[oq_wr_q] <= emit_res;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> (oq_cnt_q != 2'd2))
    else $error("result queue written while full");

  a_hw_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hw_q >= oha_pkg::FIRST_HANDLE_C) && (hw_q <= oha_pkg::TABLE_SIZE_C))
    else $error("high-water mark out of bounds");

  a_free_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_cnt_q <= (hw_q - oha_pkg::FIRST_HANDLE_C))
    else $error("more free handles than handles handed out");

  a_release_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && head_o.released) |-> (head_o.status == oha_pkg::STAT_OK))
    else $error("release reported with error status");

  a_deq_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    deq_o |=> (state_q != S_IDLE))
    else $error("item taken without leaving idle");

endmodule

`default_nettype wire

>>> hdl/owned_handle_allocator_top.sv
// Top level of the owned handle allocator: front decode queue and back table engine.
// Depends on oha_pkg, oha_front and oha_back.
//
//   channel   ports                       handshake
//   command   command_i .. object_is_dir_i push / full
//   result    result_handle_o .. last_o   empty / pop
//
// In the back engine, acquire, release, validate, get and unknown commands read the
// entry table and free stack in the idle state, then execute in the exec state.
// A sweep walks the handles from the first handle up to the high-water mark, reads
// each active entry, releases those of the sweeping owner, then emits a last result.
// Reset clears the active bits and the free count and sets the high-water mark to
// the first handle at once; no clearing pass. A full result queue stalls the engine,
// a busy engine fills the two-entry command queue and then raises full.
`default_nettype none

module owned_handle_allocator_top (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           push,
  output logic                          full,
  input  wire  [oha_pkg::CMD_W-1:0]     command_i,
  input  wire  [oha_pkg::HANDLE_W-1:0]  handle_i,
  input  wire  [oha_pkg::OWNER_W-1:0]   owner_id_i,
  input  wire  [oha_pkg::OBJ_W-1:0]     object_ref_i,
  input  wire                           object_is_dir_i,
  output logic                          empty,
  input  wire                           pop,
  output logic [oha_pkg::HANDLE_W-1:0]  result_handle_o,
  output logic [oha_pkg::OBJ_W-1:0]     result_object_o,
  output logic                          result_is_dir_o,
  output logic [1:0]                    status_o,
  output logic                          released_o,
  output logic                          last_o
);

  oha_pkg::oha_req_t req;
  oha_pkg::oha_res_t head;
  logic              deq;

  oha_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push            (push),
    .full            (full),
    .command_i       (command_i),
    .handle_i        (handle_i),
    .owner_id_i      (owner_id_i),
    .object_ref_i    (object_ref_i),
    .object_is_dir_i (object_is_dir_i),
    .deq_i           (deq),
    .req_o           (req)
  );

  oha_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .deq_o  (deq),
    .pop    (pop),
    .empty  (empty),
    .head_o (head)
  );

  assign result_handle_o = head.handle;
  assign result_object_o = head.obj;
  assign result_is_dir_o = head.is_dir;
  assign status_o        = head.status;
  assign released_o      = head.released;
  assign last_o          = head.last;

endmodule

`default_nettype wire

>>> sim/tb_owned_handle_allocator_top.sv
// Self-checking testbench for owned_handle_allocator_top: directed and random commands,
// results compared field by field against an in-bench model of the handle table.
// Depends on oha_pkg and the allocator RTL.
`timescale 1ns / 100ps

module tb_owned_handle_allocator_top;

  localparam int CYCLE_LIMIT  = 1000000;
  localparam int DRAIN_CYCLES = 150;
  localparam int RANDOM_CMDS  = 340;
  localparam int FILL_AT      = 150;

  localparam logic [oha_pkg::CMD_W-1:0] CMD_SPARE_LO = oha_pkg::CMD_SWEEP + 3'd1;
  localparam logic [oha_pkg::CMD_W-1:0] CMD_SPARE_HI = '1;

  typedef struct {
    logic [oha_pkg::CMD_W-1:0]    cmd;
    logic [oha_pkg::HANDLE_W-1:0] handle;
    logic [oha_pkg::OWNER_W-1:0]  owner;
    logic [oha_pkg::OBJ_W-1:0]    obj;
    logic                         dir;
  } table_cmd_t;

  typedef enum logic [1:0] {
    SINK_STEADY,
    SINK_RANDOM,
    SINK_PATTERN
  } sink_mode_e;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         push = 1'b0;
  logic                         full;
  logic [oha_pkg::CMD_W-1:0]    command_i = '0;
  logic [oha_pkg::HANDLE_W-1:0] handle_i = '0;
  logic [oha_pkg::OWNER_W-1:0]  owner_id_i = '0;
  logic [oha_pkg::OBJ_W-1:0]    object_ref_i = '0;
  logic                         object_is_dir_i = 1'b0;
  logic                         empty;
  logic                         pop = 1'b0;
  logic [oha_pkg::HANDLE_W-1:0] result_handle_o;
  logic [oha_pkg::OBJ_W-1:0]    result_object_o;
  logic                         result_is_dir_o;
  logic [1:0]                   status_o;
  logic                         released_o;
  logic                         last_o;

  owned_handle_allocator_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push            (push),
    .full            (full),
    .command_i       (command_i),
    .handle_i        (handle_i),
    .owner_id_i      (owner_id_i),
    .object_ref_i    (object_ref_i),
    .object_is_dir_i (object_is_dir_i),
    .empty           (empty),
    .pop             (pop),
    .result_handle_o (result_handle_o),
    .result_object_o (result_object_o),
    .result_is_dir_o (result_is_dir_o),
    .status_o        (status_o),
    .released_o      (released_o),
    .last_o          (last_o)
  );

  always #5 clk_i = ~clk_i;

  // Handle table model
  logic [oha_pkg::OBJ_W-1:0]    table_object [oha_pkg::TABLE_SIZE];
  logic [oha_pkg::OWNER_W-1:0]  table_owner  [oha_pkg::TABLE_SIZE];
  logic                         table_dir    [oha_pkg::TABLE_SIZE];
  logic                         table_live   [oha_pkg::TABLE_SIZE];
  logic [oha_pkg::HANDLE_W-1:0] recycled     [oha_pkg::TABLE_SIZE];
  int                           recycled_count = 0;
  int                           next_fresh = oha_pkg::FIRST_HANDLE;

  table_cmd_t                   pending_cmds[$];
  oha_pkg::oha_res_t            expected_results[$];
  logic [oha_pkg::OWNER_W-1:0]  owner_pool[8];

  int cmds_issued = 0;
  int cmds_accepted = 0;
  int results_checked = 0;
  int mismatches = 0;
  int sweeps_seen = 0;
  int full_answers = 0;
  int releases_seen = 0;
  int cycle_count = 0;
  logic in_fire = 1'b0;

  initial begin
    for (int i = 0; i < oha_pkg::TABLE_SIZE; i++) table_live[i] = 1'b0;
  end

  function automatic void retire_handle(input int h);
    table_live[h] = 1'b0;
    if (recycled_count < oha_pkg::TABLE_SIZE) begin
      recycled[recycled_count] = oha_pkg::HANDLE_W'(h);
      recycled_count++;
    end
    releases_seen++;
  endfunction

  // Advance the table model by one accepted command and queue its results.
  function automatic void predict_command(input table_cmd_t c);
    oha_pkg::oha_res_t r;
    int                h;
    r = '0;
    r.last = 1'b1;
    h = c.handle;
    case (c.cmd)
      oha_pkg::CMD_ACQUIRE: begin
        if (recycled_count != 0) begin
          recycled_count--;
          h = recycled[recycled_count];
        end else if (next_fresh < oha_pkg::TABLE_SIZE) begin
          h = next_fresh;
          next_fresh++;
        end else begin
          h = -1;
        end
        if (h < 0) begin
          r.status = oha_pkg::STAT_FULL;
          full_answers++;
        end else begin
          table_object[h] = c.obj;
          table_owner[h]  = c.owner;
          table_dir[h]    = c.dir;
          table_live[h]   = 1'b1;
          r.handle = oha_pkg::HANDLE_W'(h);
          r.obj    = c.obj;
          r.is_dir = c.dir;
        end
      end
      oha_pkg::CMD_RELEASE, oha_pkg::CMD_VALIDATE, oha_pkg::CMD_GET: begin
        r.handle = c.handle;
        if (h < oha_pkg::FIRST_HANDLE || h >= next_fresh) begin
          r.status = oha_pkg::STAT_RANGE;
        end else if (!table_live[h] || table_owner[h] != c.owner) begin
          r.status = oha_pkg::STAT_FOREIGN;
        end else begin
          r.status = oha_pkg::STAT_OK;
          r.obj    = table_object[h];
          r.is_dir = table_dir[h];
          if (c.cmd == oha_pkg::CMD_RELEASE) begin
            retire_handle(h);
            r.released = 1'b1;
          end
        end
      end
      oha_pkg::CMD_SWEEP: begin
        oha_pkg::oha_res_t rel;
        sweeps_seen++;
        for (int i = oha_pkg::FIRST_HANDLE; i < next_fresh; i++) begin
          if (table_live[i] && table_owner[i] == c.owner) begin
            retire_handle(i);
            rel = '0;
            rel.handle   = oha_pkg::HANDLE_W'(i);
            rel.obj      = table_object[i];
            rel.is_dir   = table_dir[i];
            rel.status   = oha_pkg::STAT_OK;
            rel.released = 1'b1;
            expected_results.push_back(rel);
          end
        end
      end
      default: begin
      end
    endcase
    expected_results.push_back(r);
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endfunction

  // Sample both handshakes at the rising edge.
  always @(posedge clk_i) begin : result_monitor
    table_cmd_t        c;
    oha_pkg::oha_res_t want;
    if (rst_ni) begin
      if (push && !full) begin
        c.cmd    = command_i;
        c.handle = handle_i;
        c.owner  = owner_id_i;
        c.obj    = object_ref_i;
        c.dir    = object_is_dir_i;
        predict_command(c);
        cmds_accepted++;
      end
      if (pop && !empty) begin
        results_checked++;
        if (expected_results.size() == 0) begin
          $error("unexpected item: handle %0h status %0h last %0b",
                 result_handle_o, status_o, last_o);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          check_field("result_handle", want.handle, result_handle_o);
          check_field("result_object", want.obj, result_object_o);
          check_field("result_is_dir", want.is_dir, result_is_dir_o);
          check_field("status", want.status, status_o);
          check_field("released", want.released, released_o);
          check_field("last", want.last, last_o);
        end
      end
    end
    in_fire <= rst_ni && push && !full;
  end

  // Sender: bursts of random length separated by random gaps.
  int burst_left = 0;
  int gap_left = 0;

  always @(negedge clk_i) begin : cmd_driver
    logic       go;
    table_cmd_t c;
    go = push;
    if (rst_ni && (!push || in_fire)) begin
      go = 1'b0;
      if (gap_left != 0) begin
        gap_left--;
      end else if (pending_cmds.size() != 0) begin
        c = pending_cmds.pop_front();
        command_i       <= c.cmd;
        handle_i        <= c.handle;
        owner_id_i      <= c.owner;
        object_ref_i    <= c.obj;
        object_is_dir_i <= c.dir;
        go = 1'b1;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        end else begin
          burst_left--;
        end
      end
    end
    push <= go;
  end

  // Receiver: stall on its own pattern, with stretches of steady draining.
  sink_mode_e  sink_mode = SINK_STEADY;
  int          sink_span = 0;
  logic [31:0] sink_bits = '1;

  always @(negedge clk_i) begin : result_sink
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (sink_span == 0) begin
        sink_mode = sink_mode_e'($urandom_range(0, 2));
        sink_span = $urandom_range(20, 200);
        sink_bits = $urandom | 32'h0101_0101;
      end
      sink_span--;
      case (sink_mode)
        SINK_STEADY: pop <= 1'b1;
        SINK_RANDOM: pop <= ($urandom_range(0, 3) != 0);
        default: begin
          pop <= sink_bits[0];
          sink_bits = {sink_bits[0], sink_bits[31:1]};
        end
      endcase
    end
  end

  always @(posedge clk_i) begin : watchdog
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic void add_cmd(input logic [oha_pkg::CMD_W-1:0] cmd, input int h,
                                  input logic [oha_pkg::OWNER_W-1:0] who,
                                  input logic [oha_pkg::OBJ_W-1:0] obj, input logic dir);
    table_cmd_t c;
    c.cmd    = cmd;
    c.handle = oha_pkg::HANDLE_W'(h);
    c.owner  = who;
    c.obj    = obj;
    c.dir    = dir;
    pending_cmds.push_back(c);
    cmds_issued++;
  endfunction

  function automatic logic [oha_pkg::OWNER_W-1:0] pick_owner();
    return owner_pool[$urandom_range(0, 7)];
  endfunction

  function automatic logic [oha_pkg::CMD_W-1:0] CMD_WIDTH_SPARE();
    return oha_pkg::CMD_W'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
  endfunction

  initial begin : stimulus
    int                           roll;
    int                           h;
    int                           live[$];
    logic [oha_pkg::CMD_W-1:0]    cmd;
    logic [oha_pkg::OWNER_W-1:0]  who;
    owner_pool[0] = '0;
    owner_pool[1] = '1;
    for (int i = 2; i < 8; i++) owner_pool[i] = oha_pkg::OWNER_W'($urandom);

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: allocation order, every check outcome, LIFO reuse, sweeps, spare codes.
    add_cmd(oha_pkg::CMD_ACQUIRE,  0, 16'h1234, 32'hFFFF_FFFF, 1'b1);
    add_cmd(oha_pkg::CMD_ACQUIRE,  0, 16'hFFFF, 32'h0000_0000, 1'b0);
    add_cmd(oha_pkg::CMD_ACQUIRE,  0, 16'h1234, 32'hA5A5_5A5A, 1'b0);
    add_cmd(oha_pkg::CMD_VALIDATE, 3, 16'h1234, '0, 1'b0);
    add_cmd(oha_pkg::CMD_GET,      4, 16'hFFFF, '0, 1'b0);
    add_cmd(oha_pkg::CMD_GET,      4, 16'h1234, '0, 1'b0);
    add_cmd(oha_pkg::CMD_RELEASE,  0, 16'h1234, '1, 1'b1);
    add_cmd(oha_pkg::CMD_RELEASE,  2, 16'h1234, '0, 1'b0);
    add_cmd(oha_pkg::CMD_VALIDATE, 63, 16'hFFFF, '0, 1'b0);
    add_cmd(oha_pkg::CMD_GET,      6, 16'h1234, '0, 1'b0);
    add_cmd(oha_pkg::CMD_RELEASE,  3, 16'h1234, '0, 1'b0);
    add_cmd(oha_pkg::CMD_VALIDATE, 3, 16'h1234, '0, 1'b0);
    add_cmd(oha_pkg::CMD_RELEASE,  3, 16'h1234, '0, 1'b0);
    add_cmd(oha_pkg::CMD_ACQUIRE,  0, 16'hFFFF, 32'h0BAD_F00D, 1'b1);
    add_cmd(oha_pkg::CMD_RELEASE,  5, 16'h1234, '0, 1'b0);
    add_cmd(oha_pkg::CMD_ACQUIRE,  0, 16'h0000, 32'h1357_9BDF, 1'b1);
    add_cmd(oha_pkg::CMD_SWEEP,    0, 16'h1234, '0, 1'b0);
    add_cmd(oha_pkg::CMD_SWEEP,    0, 16'hFFFF, '0, 1'b0);
    add_cmd(CMD_SPARE_LO, 63, 16'hFFFF, '1, 1'b1);
    add_cmd(CMD_SPARE_LO + 3'd1, 21, 16'h5555, 32'h5555_5555, 1'b0);
    add_cmd(CMD_SPARE_HI, 42, 16'hAAAA, 32'hAAAA_AAAA, 1'b1);
    add_cmd(oha_pkg::CMD_SWEEP,    0, 16'h0000, '0, 1'b0);
    add_cmd(oha_pkg::CMD_ACQUIRE,  0, 16'hFFFF, 32'h8000_0001, 1'b0);

    for (int n = 0; n < RANDOM_CMDS; n++) begin
      while (pending_cmds.size() > 1) @(negedge clk_i);
      if (n == FILL_AT) begin
        // Empty the table, fill it with one owner past full, then sweep it all back.
        for (int i = 0; i < 8; i++) add_cmd(oha_pkg::CMD_SWEEP, 0, owner_pool[i], '0, 1'b0);
        who = pick_owner();
        for (int i = 0; i < oha_pkg::TABLE_SIZE + 2; i++)
          add_cmd(oha_pkg::CMD_ACQUIRE, 0, who, oha_pkg::OBJ_W'($urandom), 1'($urandom));
        add_cmd(oha_pkg::CMD_SWEEP, 0, who, '0, 1'b0);
        n += oha_pkg::TABLE_SIZE + 10;
        continue;
      end
      roll = $urandom_range(0, 99);
      if (roll < 35) begin
        add_cmd(oha_pkg::CMD_ACQUIRE, 0, pick_owner(), oha_pkg::OBJ_W'($urandom),
                1'($urandom));
      end else if (roll < 85) begin
        cmd = (roll < 55) ? oha_pkg::CMD_RELEASE :
              (roll < 70) ? oha_pkg::CMD_VALIDATE : oha_pkg::CMD_GET;
        live = {};
        for (int i = oha_pkg::FIRST_HANDLE; i < next_fresh; i++)
          if (table_live[i]) live.push_back(i);
        if (live.size() != 0 && $urandom_range(0, 3) != 0) begin
          h = live[$urandom_range(0, live.size() - 1)];
          who = ($urandom_range(0, 7) == 0) ? pick_owner() : table_owner[h];
        end else begin
          h = $urandom_range(0, oha_pkg::TABLE_SIZE - 1);
          who = pick_owner();
        end
        add_cmd(cmd, h, who, oha_pkg::OBJ_W'($urandom), 1'($urandom));
      end else if (roll < 93) begin
        add_cmd(oha_pkg::CMD_SWEEP, $urandom_range(0, 63), pick_owner(),
                oha_pkg::OBJ_W'($urandom), 1'($urandom));
      end else if (roll < 96) begin
        add_cmd(CMD_WIDTH_SPARE(), $urandom_range(0, 63), oha_pkg::OWNER_W'($urandom),
                oha_pkg::OBJ_W'($urandom), 1'($urandom));
      end else begin
        // Noise: arbitrary handle and owner on a checking command.
        add_cmd(oha_pkg::CMD_W'($urandom_range(oha_pkg::CMD_RELEASE, oha_pkg::CMD_GET)),
                $urandom_range(0, 63), oha_pkg::OWNER_W'($urandom),
                oha_pkg::OBJ_W'($urandom), 1'($urandom));
      end
    end

    while (cmds_accepted != cmds_issued) @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Ran %0d commands (%0d owner sweeps, %0d table-full answers).",
             cmds_accepted, sweeps_seen, full_answers);
    $display("Compared %0d results field by field; %0d handles released for closing.",
             results_checked, releases_seen);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

>>> files.f
hdl/oha_pkg.sv
hdl/oha_front.sv
hdl/oha_back.sv
hdl/owned_handle_allocator_top.sv
sim/tb_owned_handle_allocator_top.sv
